// ===== hw/rtl/msss_pkg.sv =====
// ----------------------------------------------------------------------------
// msss_pkg
// Shared types and constants for the multi-stack shared store: word formats,
// store access bundle, status codes and sequencer states.
// ----------------------------------------------------------------------------
package msss_pkg;

	// Sizing
	localparam int NUM_STACKS  = 8;
	localparam int STORE_DEPTH = 64;
	localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	// Link values cover every entry plus the null code STORE_DEPTH
	localparam int LINK_W      = $clog2(STORE_DEPTH + 1);
	localparam int SEL_W       = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
	localparam int SID_W       = 3;
	localparam int DATA_W      = 32;

	localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(STORE_DEPTH);

	// Request codes
	localparam logic REQ_PUSH = 1'b0;
	localparam logic REQ_POP  = 1'b1;

	typedef enum logic [1:0] {
		STATUS_DONE  = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOKUP,
		S_COMMIT
	} seq_state_t;

	// Input word
	typedef struct packed {
		logic                     req_type;
		logic [SID_W-1:0]         stack_id;
		logic signed [DATA_W-1:0] push_value;
	} item_t;

	// Output word
	typedef struct packed {
		status_t                  status;
		logic signed [DATA_W-1:0] pop_value;
	} result_t;

	// Sequencer to store
	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic              wr_data_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [LINK_W-1:0] wr_link;
		logic [DATA_W-1:0] wr_data;
	} store_req_t;

	// Store to sequencer
	typedef struct packed {
		logic [LINK_W-1:0] link;
		logic [DATA_W-1:0] data;
	} store_rsp_t;

endpackage

// ===== hw/rtl/msss_store.sv =====
// ----------------------------------------------------------------------------
// msss_store
// Entry store: data memory and link memory sharing one read port and one
// write port. Link entries never written read as the reset chain (i -> i+1).
// ----------------------------------------------------------------------------
module msss_store
	import msss_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  store_req_t req,
	output store_rsp_t rsp
);

	logic [DATA_W-1:0]      data_mem [STORE_DEPTH];
	logic [LINK_W-1:0]      link_mem [STORE_DEPTH];
	logic [STORE_DEPTH-1:0] link_vld_q;
	logic [DATA_W-1:0]      rd_data_q;
	logic [LINK_W-1:0]      rd_link_q;
	logic [ADDR_W-1:0]      rd_addr_q;
	logic                   rd_vld_q;

	// Write and registered read of both memories
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			link_mem[req.wr_addr] <= req.wr_link;
			if (req.wr_data_en) begin
				data_mem[req.wr_addr] <= req.wr_data;
			end
		end
		if (req.rd_en) begin
			rd_link_q <= link_mem[req.rd_addr];
			rd_data_q <= data_mem[req.rd_addr];
			rd_addr_q <= req.rd_addr;
		end
	end

	// Track which link entries hold written values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_vld_q <= '0;
			rd_vld_q   <= 1'b0;
		end else begin
			if (req.wr_en) begin
				link_vld_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_vld_q <= link_vld_q[req.rd_addr];
			end
		end
	end

	// Unwritten link reads as next entry; the last one yields the null code
	assign rsp.link = rd_vld_q ? rd_link_q : LINK_W'(rd_addr_q) + LINK_W'(1);
	assign rsp.data = rd_data_q;

endmodule

// ===== hw/rtl/msss_ctrl.sv =====
// ----------------------------------------------------------------------------
// msss_ctrl
// Request sequencer: holds the stack heads and the free-list head, looks up
// the entry, reads its link and data from the store, then commits the list
// updates and registers the result word.
// ----------------------------------------------------------------------------
module msss_ctrl
	import msss_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  item_t      in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output result_t    out_data,
	output store_req_t store_req,
	input  store_rsp_t store_rsp
);

	seq_state_t        state_q, state_d;
	logic              req_q;
	logic [SID_W-1:0]  sid_q;
	logic [DATA_W-1:0] val_q;
	logic [ADDR_W-1:0] idx_q;
	logic              err_q;
	logic [LINK_W-1:0] stack_head_q [NUM_STACKS];
	logic [LINK_W-1:0] free_head_q;
	logic              out_valid_q;
	result_t           out_data_q;

	logic [SEL_W-1:0]  sel;
	logic [LINK_W-1:0] head_cur;
	logic              sid_ok;
	logic              lookup_err;
	logic              commit_fire;

	// Decode the addressed head
	always_comb begin
		sel        = SEL_W'(sid_q);
		sid_ok     = 32'(sid_q) < 32'(NUM_STACKS);
		head_cur   = (req_q == REQ_POP) ? stack_head_q[sel] : free_head_q;
		lookup_err = !sid_ok || (head_cur >= LINK_NULL);
	end

	// Next state and store access
	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		commit_fire = 1'b0;
		store_req   = '0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = S_LOOKUP;
				end
			end
			S_LOOKUP: begin
				store_req.rd_en   = !lookup_err;
				store_req.rd_addr = head_cur[ADDR_W-1:0];
				state_d           = S_COMMIT;
			end
			S_COMMIT: begin
				commit_fire = !out_valid_q || out_ready;
				if (commit_fire) begin
					in_ready             = 1'b1;
					state_d              = in_valid ? S_LOOKUP : S_IDLE;
					store_req.wr_en      = !err_q;
					store_req.wr_data_en = (req_q == REQ_PUSH);
					store_req.wr_addr    = idx_q;
					store_req.wr_link    = (req_q == REQ_PUSH) ? stack_head_q[sel]
						: free_head_q;
					store_req.wr_data    = val_q;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Capture the request word and the looked-up entry
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_q <= in_data.req_type;
			sid_q <= in_data.stack_id;
			val_q <= in_data.push_value;
		end
		if (state_q == S_LOOKUP) begin
			idx_q <= head_cur[ADDR_W-1:0];
			err_q <= lookup_err;
		end
	end

	// Update the list heads on commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_STACKS; i++) begin
				stack_head_q[i] <= LINK_NULL;
			end
			free_head_q <= '0;
		end else if (commit_fire && !err_q) begin
			if (req_q == REQ_PUSH) begin
				free_head_q       <= store_rsp.link;
				stack_head_q[sel] <= LINK_W'(idx_q);
			end else begin
				stack_head_q[sel] <= store_rsp.link;
				free_head_q       <= LINK_W'(idx_q);
			end
		end
	end

	// Hold the result word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit_fire) begin
			if (err_q) begin
				out_data_q.status <= (req_q == REQ_PUSH) ? STATUS_FULL : STATUS_EMPTY;
			end else begin
				out_data_q.status <= STATUS_DONE;
			end
			out_data_q.pop_value <= (!err_q && req_q == REQ_POP) ? store_rsp.data : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== hw/rtl/multi_stack_shared_store.sv =====
// ----------------------------------------------------------------------------
// multi_stack_shared_store
// Several LIFO stacks sharing one entry store, linked through a next-entry
// memory with a free list threading the unused entries.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready/in_data carries one request word: push
//   push_value onto stack stack_id, or pop from it. Output channel
//   out_valid/out_ready/out_data returns exactly one result word per
//   request: status (done, store full, stack empty) and the popped value.
//   Each request passes a lookup state, which picks the head and reads the
//   store, then a commit state, which writes the links and the result word.
//   No new request is taken during the lookup, set by the dependent head
//   lookup followed by the registered read of the shared store port.
//   The request after a committing one is taken in the commit cycle.
//   A stalled receiver holds the result word in the output register; the
//   block finishes nothing further until it is taken, and accepts one more at most.
//   Reset: all stacks empty, free list threads every entry in order. No
//   clearing pass is needed; unwritten link entries read as the reset chain.
// ----------------------------------------------------------------------------
module multi_stack_shared_store
	import msss_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  item_t   in_data,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	store_req_t store_req;
	store_rsp_t store_rsp;

	// Sequencer
	msss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.store_req (store_req),
		.store_rsp (store_rsp)
	);

	// Entry store
	msss_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (store_req),
		.rsp    (store_rsp)
	);

endmodule

// ===== hw/rtl/msss_checker.sv =====
// ----------------------------------------------------------------------------
// msss_checker
// Port-level checks on the multi-stack shared store, bound to the top level.
// ----------------------------------------------------------------------------
module msss_checker
	import msss_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    in_valid,
	input logic    in_ready,
	input item_t   in_data,
	input logic    out_valid,
	input logic    out_ready,
	input result_t out_data
);

	// Stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	// Failed results carry a zero value
	a_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != STATUS_DONE |-> out_data.pop_value == '0)
		else $error("nonzero value on failed request");

	// No new request in the cycle after one is taken
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken during lookup");

	// Offered request word holds until taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("request word changed while waiting");

endmodule

bind multi_stack_shared_store msss_checker u_msss_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

// ===== sim/tb_multi_stack_shared_store.sv =====
// ----------------------------------------------------------------------------
// tb_multi_stack_shared_store
// Self-checking testbench for the multi-stack shared store. A predictor keeps
// its own copy of the entry store, link chain, stack heads and free list, and
// it computes the result word for every request word that the block takes.
// Directed requests come first, then a fill/drain sweep, a receiver stall, a
// long random mix and a second sweep. Both sides idle at random, with one quiet stretch.
// ----------------------------------------------------------------------------
module tb_multi_stack_shared_store
	import msss_pkg::*;
();

	typedef struct packed {
		item_t   req;
		result_t res;
	} expect_t;

	logic    clk;
	logic    arst_n;
	logic    in_valid;
	logic    in_ready;
	item_t   in_data;
	logic    out_valid;
	logic    out_ready;
	result_t out_data;

	// Shadow copy of the block state
	logic [DATA_W-1:0] shadow_data [STORE_DEPTH];
	logic [LINK_W-1:0] shadow_link [STORE_DEPTH];
	logic [LINK_W-1:0] shadow_top  [NUM_STACKS];
	logic [LINK_W-1:0] shadow_free;
	int                shadow_depth [NUM_STACKS];
	int                live_entries;

	expect_t pending_results [$];
	int      mismatches = 0;
	int      n_push = 0, n_pop = 0, n_full = 0, n_empty = 0;
	bit      tx_idle_on = 1'b1;
	bit      rx_idle_on = 1'b1;
	int      rx_hold_left = 0;

	multi_stack_shared_store uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard limit on the run
	initial begin
		#3000000;
		$display("CHECKS FAILED");
		$finish;
	end

	// Put the shadow state in its reset condition
	function automatic void clear_shadow();
		for (int i = 0; i < STORE_DEPTH; i++) begin
			shadow_data[i] = '0;
			shadow_link[i] = LINK_W'(i + 1);
		end
		shadow_link[STORE_DEPTH-1] = LINK_NULL;
		for (int s = 0; s < NUM_STACKS; s++) begin
			shadow_top[s]   = LINK_NULL;
			shadow_depth[s] = 0;
		end
		shadow_free  = '0;
		live_entries = 0;
	endfunction

	// Apply one request to the shadow state and return the result word
	function automatic result_t apply_request(item_t w);
		result_t           r;
		logic [ADDR_W-1:0] idx;
		int                sid;
		r.status    = STATUS_DONE;
		r.pop_value = '0;
		sid         = int'(w.stack_id);
		if (w.req_type == REQ_PUSH) begin
			n_push++;
			if (sid >= NUM_STACKS || shadow_free >= STORE_DEPTH) begin
				r.status = STATUS_FULL;
				n_full++;
			end else begin
				idx              = shadow_free[ADDR_W-1:0];
				shadow_free      = shadow_link[idx];
				shadow_data[idx] = w.push_value;
				shadow_link[idx] = shadow_top[sid];
				shadow_top[sid]  = LINK_W'(idx);
				shadow_depth[sid]++;
				live_entries++;
			end
		end else begin
			n_pop++;
			if (sid >= NUM_STACKS || shadow_top[sid] >= STORE_DEPTH) begin
				r.status = STATUS_EMPTY;
				n_empty++;
			end else begin
				idx              = shadow_top[sid][ADDR_W-1:0];
				shadow_top[sid]  = shadow_link[idx];
				r.pop_value      = shadow_data[idx];
				shadow_link[idx] = shadow_free;
				shadow_free      = LINK_W'(idx);
				shadow_depth[sid]--;
				live_entries--;
			end
		end
		return r;
	endfunction

	task automatic report(input string msg);
		mismatches++;
		if (mismatches <= 10) begin
			$display("[%0t] ERROR: %s", $realtime, msg);
		end
	endtask

	// Predict the result of every word taken on the input side
	always @(posedge clk) begin : predict_blk
		expect_t e;
		if (arst_n && in_valid && in_ready) begin
			e.req = in_data;
			e.res = apply_request(in_data);
			pending_results.push_back(e);
		end
	end

	// Compare every result word with the oldest prediction
	always @(posedge clk) begin : check_blk
		expect_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report($sformatf("unexpected result: status %0d value %0d",
					out_data.status, out_data.pop_value));
			end else begin
				e = pending_results.pop_front();
				if (out_data.status !== e.res.status ||
						out_data.pop_value !== e.res.pop_value) begin
					report($sformatf({"op %0d stack %0d: expected status %0d value %0d,",
						" got status %0d value %0d"}, e.req.req_type, e.req.stack_id,
						e.res.status, e.res.pop_value, out_data.status,
						out_data.pop_value));
				end
			end
		end
	end

	// Receiver: random stalls, plus a counted hold when asked
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= !(rx_idle_on && $urandom_range(0, 99) < 19);
			end
		end
	end

	function automatic item_t word_of(logic op, int sid, logic [DATA_W-1:0] v);
		item_t w;
		w.req_type   = op;
		w.stack_id   = SID_W'(sid);
		w.push_value = v;
		return w;
	endfunction

	// Random data half the time, otherwise one of the extremes or zero
	function automatic logic [DATA_W-1:0] rand_value();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return 32'h0000_0000;
			default: return $urandom();
		endcase
	endfunction

	// Offer one word and hold it until it is taken; valid stays high after
	task automatic send_word(input item_t w);
		while (tx_idle_on && $urandom_range(0, 99) < 19) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		do begin
			@(posedge clk);
		end while (!in_ready);
	endtask

	// Drop valid and wait until every prediction has been matched
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Extremes on every stack, LIFO order, pops from empty stacks
	task automatic run_directed();
		logic [DATA_W-1:0] vals [NUM_STACKS];
		vals = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff,
			32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0001, 32'hfedc_ba98};
		send_word(word_of(REQ_POP, 0, 32'h0));
		send_word(word_of(REQ_POP, NUM_STACKS - 1, 32'hffff_ffff));
		for (int s = 0; s < NUM_STACKS; s++) begin
			send_word(word_of(REQ_PUSH, s, vals[s]));
		end
		send_word(word_of(REQ_PUSH, 0, 32'h1234_5678));
		// value field of a pop must be ignored
		send_word(word_of(REQ_POP, 0, 32'hdead_beef));
		send_word(word_of(REQ_POP, 0, 32'h0));
		send_word(word_of(REQ_POP, 0, 32'h0));
		for (int s = 1; s < NUM_STACKS; s++) begin
			send_word(word_of(REQ_POP, s, $urandom()));
		end
		wait_idle();
	endtask

	// Push until the store is full and past it, then empty every stack
	task automatic run_fill_and_drain();
		int left [NUM_STACKS];
		int total;
		int s;
		wait_idle();
		repeat (STORE_DEPTH - live_entries + 4) begin
			send_word(word_of(REQ_PUSH, $urandom_range(0, NUM_STACKS - 1), rand_value()));
		end
		wait_idle();
		total = 0;
		for (int k = 0; k < NUM_STACKS; k++) begin
			left[k] = shadow_depth[k] + 1;
			total += left[k];
		end
		while (total > 0) begin
			s = $urandom_range(0, NUM_STACKS - 1);
			if (left[s] > 0) begin
				left[s]--;
				total--;
				send_word(word_of(REQ_POP, s, $urandom()));
			end
		end
		wait_idle();
	endtask

	// Stall the receiver long enough that the block stops taking words
	task automatic run_backpressure();
		wait_idle();
		rx_hold_left = 300;
		repeat (24) begin
			send_word(word_of(($urandom_range(0, 2) == 0) ? REQ_POP : REQ_PUSH,
				$urandom_range(0, NUM_STACKS - 1), rand_value()));
		end
		wait_idle();
	endtask

	// Random mix; push bias swings occupancy between empty and full
	task automatic run_random_mix(input int count);
		bit do_push;
		int sid_max;
		for (int i = 0; i < count; i++) begin
			if (i == 300) begin
				tx_idle_on = 1'b0;
				rx_idle_on = 1'b0;
			end
			if (i == 450) begin
				tx_idle_on = 1'b1;
				rx_idle_on = 1'b1;
			end
			do_push = $urandom_range(0, 99) < ((((i / 100) % 2) == 0) ? 72 : 28);
			sid_max = (((i / 50) % 3) == 0) ? 1 : NUM_STACKS - 1;
			send_word(word_of(do_push ? REQ_PUSH : REQ_POP, $urandom_range(0, sid_max),
				rand_value()));
		end
		wait_idle();
	endtask

	// Sequence of tests
	initial begin
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		in_data  <= '0;
		clear_shadow();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		run_fill_and_drain();
		run_backpressure();
		run_random_mix(700);
		run_fill_and_drain();

		// let the pipeline settle, then look for anything left over
		wait_idle();
		repeat (8) @(posedge clk);
		if (pending_results.size() != 0) begin
			report($sformatf("%0d results never arrived", pending_results.size()));
		end

		$display("Covered %0d requests: %0d pushes (%0d refused on a full store),",
			n_push + n_pop, n_push, n_full);
		$display("%0d pops (%0d on empty stacks), %0d mismatches.", n_pop, n_empty,
			mismatches);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
